FILE: hw/rtl/dpd_pkg.sv
// dpd_pkg: shared types, widths and register codes of the dual PD drive controller
package dpd_pkg;

    // field and state widths
    localparam int CNT_W    = 16;
    localparam int ANG_E_W  = 18;
    localparam int DIST_E_W = 17;
    localparam int GAIN_W   = 8;
    localparam int DRV_W    = 10;
    localparam int SETTLE_W = 10;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // saturation value of the settle counter
    localparam logic [SETTLE_W-1:0] SETTLE_MAX = '1;

    // register reset values
    localparam logic signed [CNT_W-1:0] TARGET_DIST_RST = 16'sd0;
    localparam logic signed [CNT_W-1:0] TARGET_ANG_RST  = 16'sd0;
    localparam logic [GAIN_W-1:0] DIST_P_RST   = 8'd77;
    localparam logic [GAIN_W-1:0] DIST_D_RST   = 8'd51;
    localparam logic [GAIN_W-1:0] ANG_P_RST    = 8'd51;
    localparam logic [GAIN_W-1:0] ANG_D_RST    = 8'd51;
    localparam logic [GAIN_W-1:0] ANG_LIM_RST  = 8'd77;
    localparam logic [GAIN_W-1:0] DIST_LIM_RST = 8'd128;

    // input beat action codes
    typedef enum logic
    {
        ACT_TICK  = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    // register indexes, byte address is 4 times the index
    typedef enum logic [2:0]
    {
        REG_TARGET_DIST = 3'd0,
        REG_TARGET_ANG  = 3'd1,
        REG_DIST_P      = 3'd2,
        REG_DIST_D      = 3'd3,
        REG_ANG_P       = 3'd4,
        REG_ANG_D       = 3'd5,
        REG_ANG_LIM     = 3'd6,
        REG_DIST_LIM    = 3'd7
    } reg_idx_t;

    // configuration as seen by front and back
    typedef struct packed
    {
        logic signed [CNT_W-1:0] target_distance;
        logic signed [CNT_W-1:0] target_angle;
        logic [GAIN_W-1:0]       dist_prop_gain;
        logic [GAIN_W-1:0]       dist_deriv_gain;
        logic [GAIN_W-1:0]       ang_prop_gain;
        logic [GAIN_W-1:0]       ang_deriv_gain;
        logic [GAIN_W-1:0]       ang_corr_limit;
        logic [GAIN_W-1:0]       dist_corr_limit;
    } cfg_t;

    // classified command held in the queue
    typedef struct packed
    {
        action_t                    action;
        logic signed [ANG_E_W-1:0]  ang_err;
        logic signed [DIST_E_W-1:0] dist_err;
    } cmd_t;

    // queue status towards both sides
    typedef struct packed
    {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: hw/rtl/dpd_in_if.sv
// dpd_in_if: command channel carrying encoder counts and the action code
interface dpd_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic signed [dpd_pkg::CNT_W-1:0] left_count;
    logic signed [dpd_pkg::CNT_W-1:0] right_count;

    modport source
    (
        output valid,
        output action,
        output left_count,
        output right_count,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  action,
        input  left_count,
        input  right_count,
        output ready
    );
endinterface

FILE: hw/rtl/dpd_out_if.sv
// dpd_out_if: drive channel carrying wheel drives and the settled flag
interface dpd_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [dpd_pkg::DRV_W-1:0] left_drive;
    logic signed [dpd_pkg::DRV_W-1:0] right_drive;
    logic                             done_res;

    modport source
    (
        output valid,
        output left_drive,
        output right_drive,
        output done_res,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  left_drive,
        input  right_drive,
        input  done_res,
        output ready
    );
endinterface

FILE: hw/rtl/dual_pd_drive_controller_top.sv
// dual_pd_drive_controller_top: top level of the differential drive PD controller
//
// cmd_ch takes one beat per control tick: an action code (tick or clear) and the
// left and right encoder counts. drive_ch returns one beat per command beat with
// the left and right wheel drives in 1/256 of full PWM and the sticky settled flag.
// A clear beat zeroes the controller state and returns zero drives.
// Gains, limits and goals sit in an APB-style register file, byte address 4*index;
// write them only while no command is in flight.
// Throughput is one beat per cycle while drive_ch does not stall. A command beat
// passes the front error stage, the two-entry command queue and the back PD stage
// with its output register, whose error-state update sets the rate.
// When drive_ch stalls, the output register holds its beat, the queue fills and
// cmd_ch keeps accepting until the front stage and queue are full.
// Reset (rst_n, asynchronous, active low) empties the pipeline, zeroes the
// error state and settle counter and restores register reset values.
module dual_pd_drive_controller_top
#(
    parameter int SETTLE_COUNT = 10,
    parameter int ZERO_BAND    = 10
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    dpd_in_if.sink                     cmd_ch,
    dpd_out_if.source                  drive_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dpd_pkg::ADDR_W-1:0] paddr,
    input  logic [dpd_pkg::DATA_W-1:0] pwdata,
    output logic [dpd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    dpd_pkg::cfg_t      cfg;
    dpd_pkg::q_status_t q_stat;
    dpd_pkg::cmd_t      push_data;
    dpd_pkg::cmd_t      pop_data;
    logic               push_valid;
    logic               pop_req;

    assign pready = 1'b1;

    // configuration registers
    dpd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // front: accept and classify
    dpd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_ch     (cmd_ch),
        .cfg        (cfg),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    // command queue
    dpd_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop_req    (pop_req),
        .pop_data   (pop_data),
        .q_stat     (q_stat)
    );

    // back: PD control and drive output
    dpd_back
    #(
        .SETTLE_COUNT (SETTLE_COUNT),
        .ZERO_BAND    (ZERO_BAND)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pop_data (pop_data),
        .q_stat   (q_stat),
        .pop_req  (pop_req),
        .drive_ch (drive_ch)
    );

    // drives stay within the sum of the two largest limits
    localparam logic signed [dpd_pkg::DRV_W-1:0] DRV_MAX = 10'sd510;

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        drive_ch.valid |-> (drive_ch.left_drive <= DRV_MAX)
                        && (drive_ch.left_drive >= -DRV_MAX))
        else $error("left drive out of range");

    a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
        drive_ch.valid |-> (drive_ch.right_drive <= DRV_MAX)
                        && (drive_ch.right_drive >= -DRV_MAX))
        else $error("right drive out of range");

    // a beat entering an empty pipeline reaches the output after the front stage, the queue and the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_ch.valid && cmd_ch.ready && !push_valid && q_stat.empty && !drive_ch.valid)
        |-> ##3 drive_ch.valid)
        else $error("drive beat missing after command beat");

endmodule

FILE: hw/rtl/dpd_regs.sv
// dpd_regs: APB-style configuration register file
module dpd_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [dpd_pkg::DATA_W-1:0]   pwdata,
    output logic [dpd_pkg::DATA_W-1:0]   prdata,
    output dpd_pkg::cfg_t                cfg
);

    dpd_pkg::cfg_t     cfg_reg;
    dpd_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx   = dpd_pkg::reg_idx_t'(paddr[dpd_pkg::ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_distance <= dpd_pkg::TARGET_DIST_RST;
            cfg_reg.target_angle    <= dpd_pkg::TARGET_ANG_RST;
            cfg_reg.dist_prop_gain  <= dpd_pkg::DIST_P_RST;
            cfg_reg.dist_deriv_gain <= dpd_pkg::DIST_D_RST;
            cfg_reg.ang_prop_gain   <= dpd_pkg::ANG_P_RST;
            cfg_reg.ang_deriv_gain  <= dpd_pkg::ANG_D_RST;
            cfg_reg.ang_corr_limit  <= dpd_pkg::ANG_LIM_RST;
            cfg_reg.dist_corr_limit <= dpd_pkg::DIST_LIM_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                dpd_pkg::REG_TARGET_DIST: cfg_reg.target_distance <= pwdata[15:0];
                dpd_pkg::REG_TARGET_ANG:  cfg_reg.target_angle    <= pwdata[15:0];
                dpd_pkg::REG_DIST_P:      cfg_reg.dist_prop_gain  <= pwdata[7:0];
                dpd_pkg::REG_DIST_D:      cfg_reg.dist_deriv_gain <= pwdata[7:0];
                dpd_pkg::REG_ANG_P:       cfg_reg.ang_prop_gain   <= pwdata[7:0];
                dpd_pkg::REG_ANG_D:       cfg_reg.ang_deriv_gain  <= pwdata[7:0];
                dpd_pkg::REG_ANG_LIM:     cfg_reg.ang_corr_limit  <= pwdata[7:0];
                dpd_pkg::REG_DIST_LIM:    cfg_reg.dist_corr_limit <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    // read-back mux, values zero-extended
    always_comb
    begin
        case (idx)
            dpd_pkg::REG_TARGET_DIST: prdata = {16'b0, cfg_reg.target_distance};
            dpd_pkg::REG_TARGET_ANG:  prdata = {16'b0, cfg_reg.target_angle};
            dpd_pkg::REG_DIST_P:      prdata = {24'b0, cfg_reg.dist_prop_gain};
            dpd_pkg::REG_DIST_D:      prdata = {24'b0, cfg_reg.dist_deriv_gain};
            dpd_pkg::REG_ANG_P:       prdata = {24'b0, cfg_reg.ang_prop_gain};
            dpd_pkg::REG_ANG_D:       prdata = {24'b0, cfg_reg.ang_deriv_gain};
            dpd_pkg::REG_ANG_LIM:     prdata = {24'b0, cfg_reg.ang_corr_limit};
            dpd_pkg::REG_DIST_LIM:    prdata = {24'b0, cfg_reg.dist_corr_limit};
            default:                  prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/dpd_front.sv
// dpd_front: accepts command beats, forms angle and distance errors, feeds the queue
module dpd_front
(
    input  logic               clk,
    input  logic               rst_n,
    dpd_in_if.sink             cmd_ch,
    input  dpd_pkg::cfg_t      cfg,
    input  dpd_pkg::q_status_t q_stat,
    output logic               push_valid,
    output dpd_pkg::cmd_t      push_data
);

    logic                                stage_valid_reg;
    logic                                stage_valid_next;
    dpd_pkg::cmd_t                       stage_data_reg;
    dpd_pkg::cmd_t                       stage_data_next;
    logic                                take;
    logic                                push_ok;
    logic signed [dpd_pkg::CNT_W:0]      diff;
    logic signed [dpd_pkg::CNT_W:0]      sum;
    logic signed [dpd_pkg::CNT_W:0]      sum_adj;
    logic signed [dpd_pkg::CNT_W-1:0]    half;
    logic signed [dpd_pkg::ANG_E_W-1:0]  ang_err;
    logic signed [dpd_pkg::DIST_E_W-1:0] dist_err;

    assign push_ok      = stage_valid_reg && !q_stat.full;
    assign cmd_ch.ready = !stage_valid_reg || !q_stat.full;
    assign take         = cmd_ch.valid && cmd_ch.ready;
    assign push_valid   = stage_valid_reg;
    assign push_data    = stage_data_reg;

    // error forming, halving truncates toward zero
    always_comb
    begin
        diff     = {cmd_ch.left_count[15], cmd_ch.left_count}
                 - {cmd_ch.right_count[15], cmd_ch.right_count};
        sum      = {cmd_ch.left_count[15], cmd_ch.left_count}
                 + {cmd_ch.right_count[15], cmd_ch.right_count};
        sum_adj  = sum + {16'b0, sum[16]};
        half     = sum_adj[16:1];
        ang_err  = {{2{cfg.target_angle[15]}}, cfg.target_angle} - {diff[16], diff};
        dist_err = {cfg.target_distance[15], cfg.target_distance} - {half[15], half};
    end

    // stage register control
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_data_next  = stage_data_reg;
        if (take)
        begin
            stage_valid_next         = 1'b1;
            stage_data_next.action   = dpd_pkg::action_t'(cmd_ch.action);
            stage_data_next.ang_err  = ang_err;
            stage_data_next.dist_err = dist_err;
        end
        else if (push_ok)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_data_reg <= stage_data_next;
    end

endmodule

FILE: hw/rtl/dpd_fifo.sv
// dpd_fifo: short command queue decoupling front and back
module dpd_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  dpd_pkg::cmd_t      push_data,
    input  logic               pop_req,
    output dpd_pkg::cmd_t      pop_data,
    output dpd_pkg::q_status_t q_stat
);

    localparam int DEPTH = dpd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dpd_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_ok;
    logic             pop_ok;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign push_ok      = push_valid && !q_stat.full;
    assign pop_ok       = pop_req && !q_stat.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/dpd_back.sv
// dpd_back: PD terms, clamps, settle detection and the drive output register
module dpd_back
#(
    parameter int SETTLE_COUNT = 10,
    parameter int ZERO_BAND    = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dpd_pkg::cfg_t      cfg,
    input  dpd_pkg::cmd_t      pop_data,
    input  dpd_pkg::q_status_t q_stat,
    output logic               pop_req,
    dpd_out_if.source          drive_ch
);

    localparam logic signed [dpd_pkg::ANG_E_W:0]  BAND   = (dpd_pkg::ANG_E_W + 1)'(ZERO_BAND);
    localparam logic [dpd_pkg::SETTLE_W-1:0]      SET_LIM = dpd_pkg::SETTLE_W'(SETTLE_COUNT);

    // error state
    logic signed [dpd_pkg::ANG_E_W-1:0]  prev_ang_reg;
    logic signed [dpd_pkg::ANG_E_W-1:0]  prev_ang_next;
    logic signed [dpd_pkg::DIST_E_W-1:0] prev_dist_reg;
    logic signed [dpd_pkg::DIST_E_W-1:0] prev_dist_next;
    logic [dpd_pkg::SETTLE_W-1:0]        settle_reg;
    logic [dpd_pkg::SETTLE_W-1:0]        settle_next;
    logic                                goal_reg;
    logic                                goal_next;

    // output register
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [dpd_pkg::DRV_W-1:0]    left_reg;
    logic signed [dpd_pkg::DRV_W-1:0]    left_next;
    logic signed [dpd_pkg::DRV_W-1:0]    right_reg;
    logic signed [dpd_pkg::DRV_W-1:0]    right_next;
    logic                                done_reg;
    logic                                done_next;

    logic                                take;
    logic signed [dpd_pkg::ANG_E_W-1:0]  ang_err;
    logic signed [dpd_pkg::DIST_E_W-1:0] dist_err;
    logic signed [dpd_pkg::ANG_E_W:0]    ang_de;
    logic signed [dpd_pkg::DIST_E_W:0]   dist_de;
    logic signed [26:0]                  ang_p;
    logic signed [27:0]                  ang_d;
    logic signed [25:0]                  dist_p;
    logic signed [26:0]                  dist_d;
    logic signed [27:0]                  ang_sum;
    logic signed [27:0]                  dist_sum;
    logic signed [27:0]                  ang_lim_w;
    logic signed [27:0]                  dist_lim_w;
    logic signed [8:0]                   ang_corr;
    logic signed [8:0]                   dist_corr;
    logic signed [dpd_pkg::ANG_E_W:0]    ang_ext;
    logic signed [dpd_pkg::ANG_E_W:0]    dist_ext;
    logic                                in_band;

    assign pop_req  = !out_valid_reg || drive_ch.ready;
    assign take     = pop_req && !q_stat.empty;
    assign ang_err  = pop_data.ang_err;
    assign dist_err = pop_data.dist_err;

    assign drive_ch.valid       = out_valid_reg;
    assign drive_ch.left_drive  = left_reg;
    assign drive_ch.right_drive = right_reg;
    assign drive_ch.done_res    = done_reg;

    // PD terms with unsigned gains
    always_comb
    begin
        ang_de   = {ang_err[17], ang_err} - {prev_ang_reg[17], prev_ang_reg};
        dist_de  = {dist_err[16], dist_err} - {prev_dist_reg[16], prev_dist_reg};
        ang_p    = $signed({1'b0, cfg.ang_prop_gain}) * ang_err;
        ang_d    = $signed({1'b0, cfg.ang_deriv_gain}) * ang_de;
        dist_p   = $signed({1'b0, cfg.dist_prop_gain}) * dist_err;
        dist_d   = $signed({1'b0, cfg.dist_deriv_gain}) * dist_de;
        ang_sum  = 28'(ang_p) + ang_d;
        dist_sum = 28'(dist_p) + 28'(dist_d);
    end

    // clamp to plus or minus the limit
    always_comb
    begin
        ang_lim_w  = $signed({20'b0, cfg.ang_corr_limit});
        dist_lim_w = $signed({20'b0, cfg.dist_corr_limit});
        if (ang_sum > ang_lim_w)
        begin
            ang_corr = $signed({1'b0, cfg.ang_corr_limit});
        end
        else if (ang_sum < -ang_lim_w)
        begin
            ang_corr = -$signed({1'b0, cfg.ang_corr_limit});
        end
        else
        begin
            ang_corr = ang_sum[8:0];
        end
        if (dist_sum > dist_lim_w)
        begin
            dist_corr = $signed({1'b0, cfg.dist_corr_limit});
        end
        else if (dist_sum < -dist_lim_w)
        begin
            dist_corr = -$signed({1'b0, cfg.dist_corr_limit});
        end
        else
        begin
            dist_corr = dist_sum[8:0];
        end
    end

    // settle band check
    always_comb
    begin
        ang_ext  = {ang_err[17], ang_err};
        dist_ext = {{2{dist_err[16]}}, dist_err};
        in_band  = (ang_ext < BAND) && (ang_ext > -BAND)
                && (dist_ext < BAND) && (dist_ext > -BAND);
    end

    // state and output next values
    always_comb
    begin
        prev_ang_next  = prev_ang_reg;
        prev_dist_next = prev_dist_reg;
        settle_next    = settle_reg;
        goal_next      = goal_reg;
        out_valid_next = out_valid_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        done_next      = done_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            if (pop_data.action == dpd_pkg::ACT_CLEAR)
            begin
                prev_ang_next  = '0;
                prev_dist_next = '0;
                settle_next    = '0;
                goal_next      = 1'b0;
                left_next      = '0;
                right_next     = '0;
                done_next      = 1'b0;
            end
            else
            begin
                prev_ang_next  = ang_err;
                prev_dist_next = dist_err;
                if (in_band)
                begin
                    settle_next = (settle_reg == dpd_pkg::SETTLE_MAX) ? settle_reg
                                                                       : settle_reg + 1'b1;
                end
                else
                begin
                    settle_next = '0;
                end
                goal_next  = goal_reg || (settle_next > SET_LIM);
                left_next  = {dist_corr[8], dist_corr} + {ang_corr[8], ang_corr};
                right_next = {dist_corr[8], dist_corr} - {ang_corr[8], ang_corr};
                done_next  = goal_next;
            end
        end
        else if (drive_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ang_reg  <= '0;
            prev_dist_reg <= '0;
            settle_reg    <= '0;
            goal_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_ang_reg  <= prev_ang_next;
            prev_dist_reg <= prev_dist_next;
            settle_reg    <= settle_next;
            goal_reg      <= goal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        done_reg  <= done_next;
    end

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking testbench of the dual PD drive controller, command and drive channels
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_COUNT = 10;
    localparam int ZERO_BAND    = 10;
    localparam int PHASE_BEATS  = 55;
    localparam int NUM_PHASES   = 10;
    localparam int MAX_WAIT     = 14;
    localparam int SETTLE_RUN   = 40;

    // one drive beat as the block returns it
    typedef struct packed
    {
        logic signed [dpd_pkg::DRV_W-1:0] left_drive;
        logic signed [dpd_pkg::DRV_W-1:0] right_drive;
        logic                             done_res;
    } drive_beat_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [dpd_pkg::ADDR_W-1:0] paddr;
    logic [dpd_pkg::DATA_W-1:0] pwdata;
    logic [dpd_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    dpd_in_if  cmd_if();
    dpd_out_if drive_if();

    // shadow of the register file and of the controller state
    logic [dpd_pkg::CNT_W-1:0]           reg_val [8];
    logic signed [dpd_pkg::ANG_E_W-1:0]  prev_ang_err;
    logic signed [dpd_pkg::DIST_E_W-1:0] prev_dist_err;
    logic [dpd_pkg::SETTLE_W-1:0]        settle_cnt;
    logic                                goal_reached;

    drive_beat_t drive_expect_q [$];

    bit gaps_on;
    bit stalls_on;
    int n_errors;
    int n_ticks;
    int n_clears;
    int n_settings;
    int n_checked;
    int n_settled;

    dual_pd_drive_controller_top
    #(
        .SETTLE_COUNT (SETTLE_COUNT),
        .ZERO_BAND    (ZERO_BAND)
    )
    dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_ch   (cmd_if),
        .drive_ch (drive_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int reg_bits(dpd_pkg::reg_idx_t idx);
        return (idx == dpd_pkg::REG_TARGET_DIST || idx == dpd_pkg::REG_TARGET_ANG)
               ? dpd_pkg::CNT_W : dpd_pkg::GAIN_W;
    endfunction

    function automatic logic [dpd_pkg::CNT_W-1:0] reg_reset_value(dpd_pkg::reg_idx_t idx);
        case (idx)
            dpd_pkg::REG_TARGET_DIST: return dpd_pkg::TARGET_DIST_RST;
            dpd_pkg::REG_TARGET_ANG:  return dpd_pkg::TARGET_ANG_RST;
            dpd_pkg::REG_DIST_P:      return dpd_pkg::DIST_P_RST;
            dpd_pkg::REG_DIST_D:      return dpd_pkg::DIST_D_RST;
            dpd_pkg::REG_ANG_P:       return dpd_pkg::ANG_P_RST;
            dpd_pkg::REG_ANG_D:       return dpd_pkg::ANG_D_RST;
            dpd_pkg::REG_ANG_LIM:     return dpd_pkg::ANG_LIM_RST;
            default:                  return dpd_pkg::DIST_LIM_RST;
        endcase
    endfunction

    // drive beat that one command beat yields, advancing the shadow state
    function automatic drive_beat_t predict_drive(dpd_pkg::action_t act,
                                                  logic signed [dpd_pkg::CNT_W-1:0] lc,
                                                  logic signed [dpd_pkg::CNT_W-1:0] rc);
        drive_beat_t beat;
        int ang_err;
        int dist_err;
        int ang_corr;
        int dist_corr;
        int lim;
        int sum;
        if (act == dpd_pkg::ACT_CLEAR)
        begin
            prev_ang_err  = '0;
            prev_dist_err = '0;
            settle_cnt    = '0;
            goal_reached  = 1'b0;
            beat          = '0;
            return beat;
        end
        ang_err  = int'($signed(reg_val[dpd_pkg::REG_TARGET_ANG])) - (int'(lc) - int'(rc));
        dist_err = int'($signed(reg_val[dpd_pkg::REG_TARGET_DIST]))
                 - (int'(lc) + int'(rc)) / 2;

        // angle PD term and clamp
        ang_corr = int'(reg_val[dpd_pkg::REG_ANG_P][dpd_pkg::GAIN_W-1:0]) * ang_err
                 + int'(reg_val[dpd_pkg::REG_ANG_D][dpd_pkg::GAIN_W-1:0])
                   * (ang_err - int'(prev_ang_err));
        lim = int'(reg_val[dpd_pkg::REG_ANG_LIM][dpd_pkg::GAIN_W-1:0]);
        if (ang_corr > lim)
            ang_corr = lim;
        else if (ang_corr < -lim)
            ang_corr = -lim;
        prev_ang_err = ang_err;

        // distance PD term and clamp
        dist_corr = int'(reg_val[dpd_pkg::REG_DIST_P][dpd_pkg::GAIN_W-1:0]) * dist_err
                  + int'(reg_val[dpd_pkg::REG_DIST_D][dpd_pkg::GAIN_W-1:0])
                    * (dist_err - int'(prev_dist_err));
        lim = int'(reg_val[dpd_pkg::REG_DIST_LIM][dpd_pkg::GAIN_W-1:0]);
        if (dist_corr > lim)
            dist_corr = lim;
        else if (dist_corr < -lim)
            dist_corr = -lim;
        prev_dist_err = dist_err;

        // settle detector, saturating count and sticky flag
        if (ang_err < ZERO_BAND && ang_err > -ZERO_BAND
            && dist_err < ZERO_BAND && dist_err > -ZERO_BAND)
        begin
            if (settle_cnt != dpd_pkg::SETTLE_MAX)
                settle_cnt = settle_cnt + 1'b1;
        end
        else
        begin
            settle_cnt = '0;
        end
        if (int'(settle_cnt) > SETTLE_COUNT)
            goal_reached = 1'b1;

        sum              = dist_corr + ang_corr;
        beat.left_drive  = sum[dpd_pkg::DRV_W-1:0];
        sum              = dist_corr - ang_corr;
        beat.right_drive = sum[dpd_pkg::DRV_W-1:0];
        beat.done_res    = goal_reached;
        return beat;
    endfunction

    // one command beat, after a random gap when gaps are on
    task automatic send_cmd(dpd_pkg::action_t act, logic signed [dpd_pkg::CNT_W-1:0] lc,
                            logic signed [dpd_pkg::CNT_W-1:0] rc);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        drive_expect_q.push_back(predict_drive(act, lc, rc));
        cmd_if.valid       <= 1'b1;
        cmd_if.action      <= act;
        cmd_if.left_count  <= lc;
        cmd_if.right_count <= rc;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        if (act == dpd_pkg::ACT_CLEAR)
            n_clears++;
        else
            n_ticks++;
    endtask

    // let every outstanding drive beat come back, then idle with no command valid
    task automatic drain_pipeline();
        cmd_if.valid <= 1'b0;
        while (drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // setup and access phases, then the bus returns to idle
    task automatic apb_write(dpd_pkg::reg_idx_t idx, logic [dpd_pkg::CNT_W-1:0] value);
        logic [dpd_pkg::DATA_W-1:0] data;
        data                      = $urandom();
        data[dpd_pkg::CNT_W-1:0]  = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        // bits above the register width are dropped
        reg_val[idx] = (reg_bits(idx) == dpd_pkg::CNT_W) ? data[dpd_pkg::CNT_W-1:0]
                                                          : {8'd0, data[dpd_pkg::GAIN_W-1:0]};
    endtask

    task automatic apb_read_check(dpd_pkg::reg_idx_t idx);
        logic [dpd_pkg::DATA_W-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (reg_bits(idx) == dpd_pkg::CNT_W
            ? data[dpd_pkg::CNT_W-1:0] !== reg_val[idx]
            : data[dpd_pkg::GAIN_W-1:0] !== reg_val[idx][dpd_pkg::GAIN_W-1:0])
        begin
            $error("%s: expected %0h, got %0h", idx.name(), reg_val[idx], data);
            n_errors++;
        end
    endtask

    task automatic write_all_regs(int dist_goal, int ang_goal, int gain, int lim);
        apb_write(dpd_pkg::REG_TARGET_DIST, dist_goal);
        apb_write(dpd_pkg::REG_TARGET_ANG, ang_goal);
        apb_write(dpd_pkg::REG_DIST_P, gain);
        apb_write(dpd_pkg::REG_DIST_D, gain);
        apb_write(dpd_pkg::REG_ANG_P, gain);
        apb_write(dpd_pkg::REG_ANG_D, gain);
        apb_write(dpd_pkg::REG_ANG_LIM, lim);
        apb_write(dpd_pkg::REG_DIST_LIM, lim);
        n_settings++;
    endtask

    task automatic write_random_regs();
        dpd_pkg::reg_idx_t idx;
        int pick;
        for (int i = 0; i < 8; i++)
        begin
            idx  = dpd_pkg::reg_idx_t'(i);
            pick = $urandom_range(0, 9);
            if (reg_bits(idx) == dpd_pkg::CNT_W)
            begin
                if (pick == 0)
                    apb_write(idx, 16'h7fff);
                else if (pick == 1)
                    apb_write(idx, 16'h8000);
                else if (pick < 5)
                    apb_write(idx, $urandom());
                else
                    apb_write(idx, int'($urandom_range(0, 4000)) - 2000);
            end
            else
            begin
                if (pick == 0)
                    apb_write(idx, 0);
                else if (pick == 1)
                    apb_write(idx, 255);
                else
                    apb_write(idx, $urandom_range(0, 255));
            end
        end
        n_settings++;
    endtask

    // ticks that close in on the goals, then hover around them
    task automatic send_approach(int steps, int hover, int jit);
        int dist_goal;
        int ang_goal;
        int base_l;
        int base_r;
        int off_l;
        int off_r;
        int jl;
        int jr;
        dist_goal = int'($signed(reg_val[dpd_pkg::REG_TARGET_DIST]));
        ang_goal  = int'($signed(reg_val[dpd_pkg::REG_TARGET_ANG]));
        base_l    = dist_goal + ang_goal / 2;
        base_r    = dist_goal - ang_goal / 2;
        off_l     = int'($urandom_range(0, 4000)) - 2000;
        off_r     = int'($urandom_range(0, 4000)) - 2000;
        for (int k = steps; k > 0; k--)
            send_cmd(dpd_pkg::ACT_TICK, base_l + off_l * k / steps, base_r + off_r * k / steps);
        for (int k = 0; k < hover; k++)
        begin
            jl = int'($urandom_range(0, 2 * jit)) - jit;
            jr = int'($urandom_range(0, 2 * jit)) - jit;
            send_cmd(dpd_pkg::ACT_TICK, base_l + jl, base_r + jr);
        end
    endtask

    // reset values read back, then every register written and read back
    task automatic test_register_access();
        dpd_pkg::reg_idx_t idx;
        for (int i = 0; i < 8; i++)
            apb_read_check(dpd_pkg::reg_idx_t'(i));
        for (int i = 0; i < 8; i++)
        begin
            idx = dpd_pkg::reg_idx_t'(i);
            apb_write(idx, $urandom());
            apb_read_check(idx);
        end
        // back to reset values so the goals sit at zero
        for (int i = 0; i < 8; i++)
        begin
            idx = dpd_pkg::reg_idx_t'(i);
            apb_write(idx, reg_reset_value(idx));
        end
        n_settings++;
    endtask

    // count extremes, halving toward zero, clears, settling and sticky done
    task automatic test_directed_ticks();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_cmd(dpd_pkg::ACT_TICK, 16'sh7fff, 16'sh8000);
        send_cmd(dpd_pkg::ACT_TICK, 16'sh8000, 16'sh7fff);
        send_cmd(dpd_pkg::ACT_TICK, 16'sh7fff, 16'sh7fff);
        send_cmd(dpd_pkg::ACT_TICK, 16'sh8000, 16'sh8000);
        send_cmd(dpd_pkg::ACT_TICK, 0, 0);
        send_cmd(dpd_pkg::ACT_TICK, -3, 0);
        send_cmd(dpd_pkg::ACT_TICK, 3, 0);
        send_cmd(dpd_pkg::ACT_TICK, 16'sh8000, 16'sh8001);
        send_cmd(dpd_pkg::ACT_CLEAR, 16'sh7fff, 16'sh8000);
        send_cmd(dpd_pkg::ACT_CLEAR, -1, -1);
        for (int i = 0; i < 12; i++)
            send_cmd(dpd_pkg::ACT_TICK, i % 3, i % 2);
        send_cmd(dpd_pkg::ACT_TICK, 500, -500);
        send_cmd(dpd_pkg::ACT_TICK, 1, 1);
        send_cmd(dpd_pkg::ACT_CLEAR, 0, 0);
    endtask

    // a long in-band run at full rate keeps the settled flag up, then leaves the band
    task automatic test_long_settle();
        drain_pipeline();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        for (int i = 0; i < SETTLE_RUN; i++)
            send_cmd(dpd_pkg::ACT_TICK, i % 5 - 2, 2 - i % 5);
        send_cmd(dpd_pkg::ACT_TICK, 4000, 0);
        send_cmd(dpd_pkg::ACT_TICK, 0, 0);
        send_cmd(dpd_pkg::ACT_TICK, 1, -1);
    endtask

    // phases of register settings, each with mostly goal-seeking sequences
    task automatic test_random_phases();
        int start;
        int pick;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_pipeline();
            case (p)
                0:       write_all_regs(32767, -32768, 255, 255);
                1:       write_all_regs(-32768, 32767, 0, 0);
                2:       write_all_regs(0, 0, 255, 0);
                3:       write_all_regs(0, 0, 1, 255);
                default: write_random_regs();
            endcase
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            start     = n_ticks + n_clears;
            while (n_ticks + n_clears - start < PHASE_BEATS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    send_approach($urandom_range(1, 8), $urandom_range(0, 16),
                                  $urandom_range(1, 10));
                else if (pick < 8)
                    for (int k = $urandom_range(1, 4); k > 0; k--)
                        send_cmd(dpd_pkg::ACT_TICK, $urandom(), $urandom());
                else if (pick == 8)
                    send_cmd(dpd_pkg::ACT_CLEAR, $urandom(), $urandom());
                else
                    send_approach(1, $urandom_range(11, 14), 1);
            end
        end
    endtask

    // drive channel: random back-pressure and the beat check
    initial
    begin : drive_monitor
        drive_beat_t want;
        int stall;
        drive_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0)
            begin
                drive_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            drive_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (drive_if.valid !== 1'b1);
            if (drive_expect_q.size() == 0)
            begin
                $error("drive beat: none expected, got %0d %0d %0b", drive_if.left_drive,
                       drive_if.right_drive, drive_if.done_res);
                n_errors++;
            end
            else
            begin
                want = drive_expect_q.pop_front();
                n_checked++;
                if (drive_if.done_res === 1'b1)
                    n_settled++;
                if (drive_if.left_drive !== want.left_drive)
                begin
                    $error("left_drive: expected %0d, got %0d", want.left_drive,
                           drive_if.left_drive);
                    n_errors++;
                end
                if (drive_if.right_drive !== want.right_drive)
                begin
                    $error("right_drive: expected %0d, got %0d", want.right_drive,
                           drive_if.right_drive);
                    n_errors++;
                end
                if (drive_if.done_res !== want.done_res)
                begin
                    $error("done_res: expected %0b, got %0b", want.done_res,
                           drive_if.done_res);
                    n_errors++;
                end
            end
        end
    end

    // reset, tests in turn, verdict
    initial
    begin : stimulus
        rst_n              = 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        cmd_if.valid       <= 1'b0;
        cmd_if.action      <= dpd_pkg::ACT_TICK;
        cmd_if.left_count  <= '0;
        cmd_if.right_count <= '0;
        for (int i = 0; i < 8; i++)
            reg_val[i] = reg_reset_value(dpd_pkg::reg_idx_t'(i));
        prev_ang_err  = '0;
        prev_dist_err = '0;
        settle_cnt    = '0;
        goal_reached  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_directed_ticks();
        test_long_settle();
        test_random_phases();
        drain_pipeline();

        $display("covered %0d tick beats and %0d clear beats over %0d register settings",
                 n_ticks, n_clears, n_settings);
        $display("%0d drive beats compared, %0d of them with the settled flag up",
                 n_checked, n_settled);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
